/* sv/lifo_stack_with_palindrome_check_top_macros.svh */
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Shared concurrent assertion forms for the stack with palindrome check.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PALINDROME_CHECK_TOP_MACROS_SVH
`define LIFO_STACK_WITH_PALINDROME_CHECK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPC_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Stack assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define LSPC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Stack assertion failed.");

`endif

/* sv/lspc_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO stack package
// Request and response types, operation codes and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lspc_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int ENTRY_W   = 7;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_CHECK = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OVF   = 2'd1;
	localparam logic [1:0] STAT_UNDER = 2'd2;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [ENTRY_W-1:0]       entry_total;
		logic                     is_palindrome;
		logic [1:0]               status;
	} rsp_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

/* sv/lspc_chan_if.sv */
// ----------------------------------------------------------------------------
// LIFO stack channel interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lspc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/lspc_mem.sv */
// ----------------------------------------------------------------------------
// LIFO stack storage
// Entry memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lspc_mem #(
	parameter int DEPTH = lspc_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                              clk,
	input  wire lspc_pkg::mem_ctl_t                ctl,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic signed [lspc_pkg::DATA_W-1:0] wr_data,
	input  wire logic [AW-1:0]                     rd_addr_a,
	input  wire logic [AW-1:0]                     rd_addr_b,
	output logic signed [lspc_pkg::DATA_W-1:0]     rd_data_a,
	output logic signed [lspc_pkg::DATA_W-1:0]     rd_data_b
);

	logic signed [lspc_pkg::DATA_W-1:0] store_q [DEPTH];
	logic signed [lspc_pkg::DATA_W-1:0] rd_a_q;
	logic signed [lspc_pkg::DATA_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_a_q <= store_q[rd_addr_a];
			rd_b_q <= store_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

/* sv/lspc_seq.sv */
// ----------------------------------------------------------------------------
// LIFO stack sequencer
// Request decode, fill level, top register, pair comparator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_palindrome_check_top_macros.svh"

module lspc_seq #(
	parameter int DEPTH = lspc_pkg::DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	lspc_chan_if.sink                               req,
	lspc_chan_if.source                             rsp,
	output lspc_pkg::mem_ctl_t                      mem_ctl,
	output logic [AW-1:0]                           wr_addr,
	output logic signed [lspc_pkg::DATA_W-1:0]      wr_data,
	output logic [AW-1:0]                           rd_addr_a,
	output logic [AW-1:0]                           rd_addr_b,
	input  wire logic signed [lspc_pkg::DATA_W-1:0] rd_data_a,
	input  wire logic signed [lspc_pkg::DATA_W-1:0] rd_data_b
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_CHK  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                         state_q;
	logic [CW-1:0]                      count_q;
	logic signed [lspc_pkg::DATA_W-1:0] top_q;
	logic [AW-1:0]                      lo_q;
	logic [AW-1:0]                      hi_q;
	logic                               pal_q;
	logic [1:0]                         status_q;
	logic                               out_valid_q;
	lspc_pkg::rsp_t                     out_q;

	logic [1:0]                         nx_state;
	logic [CW-1:0]                      nx_count;
	logic signed [lspc_pkg::DATA_W-1:0] nx_top;
	logic [AW-1:0]                      nx_lo;
	logic [AW-1:0]                      nx_hi;
	logic                               nx_pal;
	logic [1:0]                         nx_status;
	logic                               out_load;
	logic                               slot_free;
	logic                               accept;
	logic                               pair_eq;
	logic [AW-1:0]                      lo_inc;
	logic [AW-1:0]                      hi_dec;
	logic                               pair_last;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;

	assign pair_eq   = (rd_data_a == rd_data_b);
	assign lo_inc    = lo_q + AW'(1);
	assign hi_dec    = hi_q - AW'(1);
	assign pair_last = (lo_inc >= hi_dec);

	assign wr_addr = AW'(count_q);
	assign wr_data = req.payload.push_value;

	always_comb begin
		nx_state   = state_q;
		nx_count   = count_q;
		nx_top     = top_q;
		nx_lo      = lo_q;
		nx_hi      = hi_q;
		nx_pal     = pal_q;
		nx_status  = status_q;
		out_load   = 1'b0;
		mem_ctl    = '0;
		rd_addr_a  = AW'(count_q - CW'(2));
		rd_addr_b  = AW'(count_q - CW'(1));
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					nx_pal    = 1'b0;
					nx_status = lspc_pkg::STAT_OK;
					out_load  = 1'b1;
					case (req.payload.req_type)
						lspc_pkg::REQ_PUSH: begin
							if (count_q == CW'(DEPTH)) begin
								nx_status = lspc_pkg::STAT_OVF;
							end else begin
								mem_ctl.wr_en = 1'b1;
								nx_count      = count_q + CW'(1);
								nx_top        = req.payload.push_value;
							end
						end
						lspc_pkg::REQ_POP: begin
							if (count_q == '0) begin
								nx_status = lspc_pkg::STAT_UNDER;
							end else if (count_q == CW'(1)) begin
								nx_count = '0;
								nx_top   = '0;
							end else begin
								mem_ctl.rd_en = 1'b1;
								nx_count      = count_q - CW'(1);
								out_load      = 1'b0;
								nx_state      = ST_POP;
							end
						end
						lspc_pkg::REQ_CLEAR: begin
							nx_count = '0;
							nx_top   = '0;
						end
						default: begin
							if (count_q < CW'(2)) begin
								nx_pal = 1'b1;
							end else begin
								mem_ctl.rd_en = 1'b1;
								rd_addr_a     = '0;
								nx_lo         = '0;
								nx_hi         = AW'(count_q - CW'(1));
								out_load      = 1'b0;
								nx_state      = ST_CHK;
							end
						end
					endcase
				end
			end
			ST_POP: begin
				nx_top   = rd_data_a;
				nx_state = ST_FIN;
			end
			ST_CHK: begin
				rd_addr_a = lo_inc;
				rd_addr_b = hi_dec;
				if (!pair_eq) begin
					nx_pal   = 1'b0;
					nx_state = ST_FIN;
				end else if (pair_last) begin
					nx_pal   = 1'b1;
					nx_state = ST_FIN;
				end else begin
					mem_ctl.rd_en = 1'b1;
					nx_lo         = lo_inc;
					nx_hi         = hi_dec;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					out_load = 1'b1;
					nx_state = ST_IDLE;
				end
			end
			default: begin
				nx_state = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nx_state;
			count_q <= nx_count;
			top_q   <= nx_top;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= nx_lo;
		hi_q     <= nx_hi;
		pal_q    <= nx_pal;
		status_q <= nx_status;
		if (out_load) begin
			out_q.top_value     <= nx_top;
			out_q.entry_total   <= lspc_pkg::ENTRY_W'(nx_count);
			out_q.is_palindrome <= nx_pal;
			out_q.status        <= nx_status;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	`LSPC_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`LSPC_ASSERT_IMPL(a_ready_idle, clk, arst_n, req.ready, state_q == ST_IDLE)
	`LSPC_ASSERT_IMPL(a_chk_order, clk, arst_n, state_q == ST_CHK, lo_q < hi_q)
	`LSPC_ASSERT_NEXT(a_pop_fin, clk, arst_n, state_q == ST_POP, state_q == ST_FIN)
	`LSPC_ASSERT_IMPL(a_ovf_full, clk, arst_n,
		rsp.valid && (rsp.payload.status == lspc_pkg::STAT_OVF),
		rsp.payload.entry_total == lspc_pkg::ENTRY_W'(DEPTH))

endmodule

`default_nettype wire

/* sv/lifo_stack_with_palindrome_check_top.sv */
// A LIFO stack of signed 32-bit words with a palindrome check. Each request
// transaction returns exactly one response transaction, held in an output
// register. Push, clear, a pop that empties the stack, a check of fewer than
// two entries, and any rejected request load the response register as soon
// as they are accepted. A pop that leaves one or more entries passes through
// a pop state and a finish state, because the new top comes from a registered
// memory read. A check of two or more entries runs in a check state, where
// one comparator looks at one entry pair per cycle, fed by the two read ports
// of the entry memory; the check ends at the first unequal pair. The request
// channel is not ready while a request is in progress or while the response
// register is full and not being taken. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check
// Top level tying the sequencer to the entry memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_palindrome_check_top #(
	parameter int DEPTH = lspc_pkg::DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lspc_chan_if.sink   req,
	lspc_chan_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	lspc_pkg::mem_ctl_t                 mem_ctl;
	logic [AW-1:0]                      wr_addr;
	logic signed [lspc_pkg::DATA_W-1:0] wr_data;
	logic [AW-1:0]                      rd_addr_a;
	logic [AW-1:0]                      rd_addr_b;
	logic signed [lspc_pkg::DATA_W-1:0] rd_data_a;
	logic signed [lspc_pkg::DATA_W-1:0] rd_data_b;

	lspc_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	lspc_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

endmodule

`default_nettype wire
